/* rtl/linear_probe_hash_table_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the linear probing hash table
// Short forms for the concurrent checks at the end of the RTL modules.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// ante must be followed by cons in the same cycle
`define LPHT_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cond must never hold
`define LPHT_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

/* rtl/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Operation, slot mark and status codes of the linear probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

   typedef logic [2:0] kind_type;
   typedef logic [1:0] mark_type;
   typedef logic [1:0] status_type;

   localparam int KEY_W  = 32;
   localparam int MARK_W = 2;
   localparam int TAG_W  = MARK_W + KEY_W;

   localparam kind_type KIND_GET    = 3'd0;
   localparam kind_type KIND_SET    = 3'd1;
   localparam kind_type KIND_DELETE = 3'd2;
   localparam kind_type KIND_CLEAR  = 3'd3;
   localparam kind_type KIND_READ   = 3'd4;

   localparam mark_type MARK_NEVER = 2'd0;
   localparam mark_type MARK_TOMB  = 2'd1;
   localparam mark_type MARK_FULL  = 2'd2;

   localparam status_type ST_DONE = 2'd0;
   localparam status_type ST_MISS = 2'd1;
   localparam status_type ST_FULL = 2'd2;

   localparam logic [8:0] LIMIT_RESET = 9'd170;
   localparam logic [8:0] USED_MAX    = 9'd511;

endpackage

`default_nettype wire

/* rtl/linear_probe_hash_table.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing hash table with linear probing, tombstones on delete and a
// load limit on new inserts. Mark and key live in one memory, values in another.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; every request gives
// exactly one response, shown for one cycle on rsp_strobe, and the receiver
// cannot hold it off. A get, set or delete reads one slot per cycle from the
// tag memory; when SLOTS is not a power of two the start slot comes from a
// reciprocal multiplication of the key, in the extra state S_MOD. A slot read
// answers from S_SLOT, an unknown operation straight from idle, and a clear
// sweeps the tag memory one entry a cycle. After reset busy stays high while
// that sweep runs. Writes to load_limit are accepted at any time; csr_ready is
// always high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table #(
   parameter int SLOTS      = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value_in,
   input  logic [7:0]  req_slot_index,

   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_value_out,
   output logic [7:0]  rsp_slot,
   output logic [1:0]  rsp_prior_mark,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_wdata
);

   localparam int IW   = $clog2(SLOTS);
   localparam int CW   = IW + 1;
   localparam bit POW2 = ((SLOTS & (SLOTS - 1)) == 0);
   localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   // key / SLOTS as (key * RECIP) >> RSH, exact for every 32-bit key
   localparam int            RSH      = 32 + IW;
   localparam logic [63:0]   RECIP    = ((64'd1 << RSH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
   localparam logic [32:0]   RECIP_C  = RECIP[32:0];
   localparam logic [IW-1:0] SLOTS_LO = IW'(SLOTS);

   localparam logic [2:0] S_SWEEP = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_PROBE = 3'd3;
   localparam logic [2:0] S_SLOT  = 3'd4;

   function automatic logic [7:0] slot_byte(input logic [IW-1:0] idx);
      logic [16:0] wide;
      wide = 17'(idx);
      return wide[7:0];
   endfunction

   // control
   logic [2:0]           state_ff, state_in;
   lpht_pkg::kind_type   op_ff, op_in;
   logic                 pend_ff, pend_in;
   logic [IW-1:0]        sweep_ff, sweep_in;
   logic [8:0]           used_ff, used_in;
   logic [8:0]           limit_ff, limit_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;

   // payload
   logic [31:0]          key_ff, key_in;
   logic [31:0]          vin_ff, vin_in;
   logic [IW-1:0]        addr_ff, addr_in;
   logic [CW-1:0]        issue_ff, issue_in;
   logic [CW-1:0]        eval_ff, eval_in;
   logic [IW-1:0]        pend_idx_ff, pend_idx_in;
   logic                 free_ok_ff, free_ok_in;
   logic [IW-1:0]        free_at_ff, free_at_in;
   lpht_pkg::mark_type   free_mark_ff, free_mark_in;
   logic [64:0]          prod_ff, prod_in;
   lpht_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [31:0]          rsp_value_ff, rsp_value_in;
   logic [7:0]           rsp_slot_ff, rsp_slot_in;
   lpht_pkg::mark_type   rsp_mark_ff, rsp_mark_in;

   // memories
   logic [lpht_pkg::TAG_W-1:0] tag_mem [SLOTS];
   logic [VALUE_BITS-1:0]      value_mem [SLOTS];
   logic [lpht_pkg::TAG_W-1:0] tag_rd_ff;
   logic [VALUE_BITS-1:0]      value_rd_ff;
   logic                       rd_en;
   logic [IW-1:0]              rd_addr;
   logic                       tag_we;
   logic [IW-1:0]              tag_wa;
   logic [lpht_pkg::TAG_W-1:0] tag_wd;
   logic                       value_we;

   // probe evaluation
   lpht_pkg::mark_type e_mark;
   logic               e_hit, e_free, e_last, e_finish, issue;
   logic               fok_n;
   logic [IW-1:0]      fat_n;
   lpht_pkg::mark_type fmark_n;
   logic [IW-1:0]      tgt_idx;
   lpht_pkg::mark_type tgt_mark;

   logic [16:0]        sidx_wide;
   logic               sidx_ok;
   logic [IW-1:0]      quo_lo, mod_prod, mod_res;
   logic [63:0]        vin_wide, vout_wide;
   logic               rsp_is_full, rsp_is_empty;

   assign busy           = (state_ff != S_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_value_out  = rsp_value_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_prior_mark = rsp_mark_ff;

   assign sidx_wide = 17'(req_slot_index);
   assign sidx_ok   = ({24'b0, req_slot_index} < 32'(SLOTS));
   assign vin_wide  = 64'(vin_ff);
   assign vout_wide = 64'(value_rd_ff);

   // remainder below SLOTS, so its low bits are enough
   assign quo_lo   = IW'(prod_ff >> RSH);
   assign mod_prod = quo_lo * SLOTS_LO;
   assign mod_res  = key_ff[IW-1:0] - mod_prod;

   assign e_mark   = tag_rd_ff[lpht_pkg::TAG_W-1:lpht_pkg::KEY_W];
   assign e_hit    = pend_ff && (e_mark == lpht_pkg::MARK_FULL)
                     && (tag_rd_ff[lpht_pkg::KEY_W-1:0] == key_ff);
   assign e_free   = pend_ff && (e_mark != lpht_pkg::MARK_FULL);
   assign e_last   = pend_ff && (eval_ff == SLOTS_C - 1'b1);
   assign e_finish = e_hit || (pend_ff && (e_mark == lpht_pkg::MARK_NEVER)) || e_last;
   assign issue    = (state_ff == S_PROBE) && (issue_ff != SLOTS_C) && !e_finish;

   assign fok_n    = free_ok_ff || e_free;
   assign fat_n    = free_ok_ff ? free_at_ff : pend_idx_ff;
   assign fmark_n  = free_ok_ff ? free_mark_ff : e_mark;
   assign tgt_idx  = e_hit ? pend_idx_ff : fat_n;
   assign tgt_mark = e_hit ? lpht_pkg::MARK_FULL : fmark_n;

   assign rsp_is_full  = rsp_strobe && (rsp_status == lpht_pkg::ST_FULL);
   assign rsp_is_empty = (rsp_slot == 8'd0) && (rsp_prior_mark == lpht_pkg::MARK_NEVER)
                         && (rsp_value_out == 32'd0);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pend_in       = 1'b0;
      sweep_in      = sweep_ff;
      used_in       = used_ff;
      limit_in      = csr_valid ? csr_wdata : limit_ff;
      rsp_strobe_in = 1'b0;
      key_in        = key_ff;
      vin_in        = vin_ff;
      addr_in       = addr_ff;
      issue_in      = issue_ff;
      eval_in       = eval_ff;
      pend_idx_in   = pend_idx_ff;
      free_ok_in    = free_ok_ff;
      free_at_in    = free_at_ff;
      free_mark_in  = free_mark_ff;
      prod_in       = prod_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_mark_in   = rsp_mark_ff;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      tag_we        = 1'b0;
      tag_wa        = tgt_idx;
      tag_wd        = {lpht_pkg::MARK_FULL, key_ff};
      value_we      = 1'b0;

      unique case (state_ff)
         S_SWEEP: begin
            tag_we   = 1'b1;
            tag_wa   = sweep_ff;
            tag_wd   = {lpht_pkg::MARK_NEVER, 32'b0};
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_IDX) begin
               state_in = S_IDLE;
               if (op_ff == lpht_pkg::KIND_CLEAR) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = lpht_pkg::ST_DONE;
                  rsp_value_in  = '0;
                  rsp_slot_in   = '0;
                  rsp_mark_in   = lpht_pkg::MARK_NEVER;
               end
            end
         end

         S_IDLE: begin
            if (start) begin
               op_in      = req_kind;
               key_in     = req_key;
               vin_in     = req_value_in;
               free_ok_in = 1'b0;
               issue_in   = '0;
               eval_in    = '0;
               case (req_kind) inside
                  lpht_pkg::KIND_GET, lpht_pkg::KIND_SET, lpht_pkg::KIND_DELETE: begin
                     addr_in  = req_key[IW-1:0];
                     prod_in  = 65'(req_key) * 65'(RECIP_C);
                     state_in = POW2 ? S_PROBE : S_MOD;
                  end
                  lpht_pkg::KIND_CLEAR: begin
                     used_in  = '0;
                     sweep_in = '0;
                     state_in = S_SWEEP;
                  end
                  lpht_pkg::KIND_READ: begin
                     if (sidx_ok) begin
                        rd_en       = 1'b1;
                        rd_addr     = sidx_wide[IW-1:0];
                        rsp_slot_in = req_slot_index;
                        state_in    = S_SLOT;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = lpht_pkg::ST_MISS;
                        rsp_value_in  = '0;
                        rsp_slot_in   = req_slot_index;
                        rsp_mark_in   = lpht_pkg::MARK_NEVER;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = lpht_pkg::ST_MISS;
                     rsp_value_in  = '0;
                     rsp_slot_in   = '0;
                     rsp_mark_in   = lpht_pkg::MARK_NEVER;
                  end
               endcase
            end
         end

         S_MOD: begin
            addr_in  = mod_res;
            state_in = S_PROBE;
         end

         S_PROBE: begin
            if (issue) begin
               rd_en       = 1'b1;
               rd_addr     = addr_ff;
               addr_in     = (addr_ff == LAST_IDX) ? '0 : addr_ff + 1'b1;
               issue_in    = issue_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = addr_ff;
            end
            if (pend_ff) begin
               eval_in      = eval_ff + 1'b1;
               free_ok_in   = fok_n;
               free_at_in   = fat_n;
               free_mark_in = fmark_n;
            end
            if (e_finish) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_status_in = lpht_pkg::ST_MISS;
               rsp_value_in  = '0;
               rsp_slot_in   = '0;
               rsp_mark_in   = lpht_pkg::MARK_NEVER;
               case (op_ff)
                  lpht_pkg::KIND_GET: begin
                     if (e_hit) begin
                        rsp_status_in = lpht_pkg::ST_DONE;
                        rsp_value_in  = vout_wide[31:0];
                        rsp_slot_in   = slot_byte(pend_idx_ff);
                        rsp_mark_in   = lpht_pkg::MARK_FULL;
                     end
                  end
                  lpht_pkg::KIND_SET: begin
                     if (!(e_hit || fok_n) ||
                         ((tgt_mark == lpht_pkg::MARK_NEVER) && (used_ff >= limit_ff))) begin
                        rsp_status_in = lpht_pkg::ST_FULL;
                     end else begin
                        tag_we        = 1'b1;
                        value_we      = 1'b1;
                        rsp_status_in = lpht_pkg::ST_DONE;
                        rsp_slot_in   = slot_byte(tgt_idx);
                        rsp_mark_in   = tgt_mark;
                        if ((tgt_mark == lpht_pkg::MARK_NEVER) &&
                            (used_ff != lpht_pkg::USED_MAX)) begin
                           used_in = used_ff + 1'b1;
                        end
                     end
                  end
                  lpht_pkg::KIND_DELETE: begin
                     if (e_hit) begin
                        tag_we        = 1'b1;
                        tag_wa        = pend_idx_ff;
                        tag_wd        = {lpht_pkg::MARK_TOMB, key_ff};
                        rsp_status_in = lpht_pkg::ST_DONE;
                        rsp_slot_in   = slot_byte(pend_idx_ff);
                        rsp_mark_in   = lpht_pkg::MARK_FULL;
                     end
                  end
                  default: begin
                     rsp_status_in = lpht_pkg::ST_MISS;
                  end
               endcase
            end
         end

         S_SLOT: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_mark_in   = e_mark;
            if (e_mark == lpht_pkg::MARK_FULL) begin
               rsp_status_in = lpht_pkg::ST_DONE;
               rsp_value_in  = vout_wide[31:0];
            end else begin
               rsp_status_in = lpht_pkg::ST_MISS;
               rsp_value_in  = '0;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         op_ff         <= lpht_pkg::KIND_GET;
         pend_ff       <= 1'b0;
         sweep_ff      <= '0;
         used_ff       <= '0;
         limit_ff      <= lpht_pkg::LIMIT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         pend_ff       <= pend_in;
         sweep_ff      <= sweep_in;
         used_ff       <= used_in;
         limit_ff      <= limit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      vin_ff        <= vin_in;
      addr_ff       <= addr_in;
      issue_ff      <= issue_in;
      eval_ff       <= eval_in;
      pend_idx_ff   <= pend_idx_in;
      free_ok_ff    <= free_ok_in;
      free_at_ff    <= free_at_in;
      free_mark_ff  <= free_mark_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_mark_ff   <= rsp_mark_in;
   end

   // mark and key memory
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_wa] <= tag_wd;
      end
      if (rd_en) begin
         tag_rd_ff <= tag_mem[rd_addr];
      end
   end

   // value memory, read alongside the tags
   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[tgt_idx] <= vin_wide[VALUE_BITS-1:0];
      end
      if (rd_en) begin
         value_rd_ff <= value_mem[rd_addr];
      end
   end

   `LPHT_ASSERT_NEVER(a_no_rd_wr_overlap, clock, reset, tag_we && rd_en, "tag read and write overlap")
   `LPHT_ASSERT_IMPL(a_idle_no_pending, clock, reset, !busy, !pend_ff, "probe data pending while idle")
   `LPHT_ASSERT_IMPL(a_rsp_when_idle, clock, reset, rsp_strobe, !busy, "response while still busy")
   `LPHT_ASSERT_IMPL(a_full_rsp_empty, clock, reset, rsp_is_full, rsp_is_empty, "full response carries data")

endmodule

`default_nettype wire

/* bench/linear_probe_hash_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Self-checking bench for the linear probing hash table. A short list of
// directed requests, some with fixed expected responses, covers the corner
// cases. Random phases follow, each under its own load limit, one of them
// filling every slot. A shadow table predicts the others; all checked in order.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb;

   localparam int SLOTS     = 256;
   localparam int POOL_SIZE = 40;

   typedef struct packed {
      lpht_pkg::kind_type kind;
      logic [31:0]        key;
      logic [31:0]        value;
      logic [7:0]         idx;
   } req_type;

   typedef struct packed {
      lpht_pkg::status_type status;
      logic [31:0]          value;
      logic [7:0]           slot;
      lpht_pkg::mark_type   mark;
   } rsp_type;

   typedef struct packed {
      req_type rq;
      bit      typed;
      rsp_type rs;
   } vec_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_kind;
   logic [31:0] req_key;
   logic [31:0] req_value_in;
   logic [7:0]  req_slot_index;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_value_out;
   logic [7:0]  rsp_slot;
   logic [1:0]  rsp_prior_mark;
   logic        csr_valid;
   logic        csr_ready;
   logic [8:0]  csr_wdata;

   // shadow copy of the table
   logic [31:0]        shadow_key  [0:SLOTS-1];
   logic [31:0]        shadow_val  [0:SLOTS-1];
   lpht_pkg::mark_type shadow_mark [0:SLOTS-1];
   logic [8:0]         shadow_used;
   logic [8:0]         shadow_limit;

   rsp_type     pending_rsp[$];
   vec_type     directed_q[$];
   logic [31:0] key_pool  [0:POOL_SIZE-1];
   logic [31:0] fill_keys [0:SLOTS-1];
   int          fault_cnt;

   linear_probe_hash_table u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_key        (req_key),
      .req_value_in   (req_value_in),
      .req_slot_index (req_slot_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_value_out  (rsp_value_out),
      .rsp_slot       (rsp_slot),
      .rsp_prior_mark (rsp_prior_mark),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // linear probe from key mod SLOTS; notes the first tombstone or empty slot
   function automatic void probe_table(input logic [31:0] k, output bit found,
                                       output logic [7:0] hit, output bit free_ok,
                                       output logic [7:0] free_at);
      logic [7:0] idx;
      bit         stop;
      int         i;
      found   = 1'b0;
      hit     = '0;
      free_ok = 1'b0;
      free_at = '0;
      stop    = 1'b0;
      idx     = k[7:0];
      for (i = 0; i < SLOTS && !stop; i++) begin
         if (shadow_mark[idx] == lpht_pkg::MARK_FULL) begin
            if (shadow_key[idx] == k) begin
               found = 1'b1;
               hit   = idx;
               stop  = 1'b1;
            end
         end else begin
            if (!free_ok) begin
               free_ok = 1'b1;
               free_at = idx;
            end
            if (shadow_mark[idx] == lpht_pkg::MARK_NEVER) stop = 1'b1;
         end
         idx = idx + 8'd1;
      end
   endfunction

   function automatic rsp_type table_response(input req_type r);
      rsp_type    o;
      bit         found;
      bit         free_ok;
      logic [7:0] hit;
      logic [7:0] free_at;
      logic [7:0] tgt;
      int         i;
      o        = '0;
      o.status = lpht_pkg::ST_MISS;
      case (r.kind)
         lpht_pkg::KIND_GET: begin
            probe_table(r.key, found, hit, free_ok, free_at);
            if (found) begin
               o.status = lpht_pkg::ST_DONE;
               o.value  = shadow_val[hit];
               o.slot   = hit;
               o.mark   = lpht_pkg::MARK_FULL;
            end
         end
         lpht_pkg::KIND_SET: begin
            probe_table(r.key, found, hit, free_ok, free_at);
            tgt = found ? hit : free_at;
            if (!found && !free_ok) begin
               o.status = lpht_pkg::ST_FULL;
            end else if (shadow_mark[tgt] == lpht_pkg::MARK_NEVER &&
                         shadow_used >= shadow_limit) begin
               o.status = lpht_pkg::ST_FULL;
            end else begin
               o.mark = shadow_mark[tgt];
               if (o.mark == lpht_pkg::MARK_NEVER && shadow_used < lpht_pkg::USED_MAX)
                  shadow_used = shadow_used + 9'd1;
               shadow_key[tgt]  = r.key;
               shadow_val[tgt]  = r.value;
               shadow_mark[tgt] = lpht_pkg::MARK_FULL;
               o.status = lpht_pkg::ST_DONE;
               o.slot   = tgt;
            end
         end
         lpht_pkg::KIND_DELETE: begin
            probe_table(r.key, found, hit, free_ok, free_at);
            if (found) begin
               shadow_mark[hit] = lpht_pkg::MARK_TOMB;
               o.status = lpht_pkg::ST_DONE;
               o.slot   = hit;
               o.mark   = lpht_pkg::MARK_FULL;
            end
         end
         lpht_pkg::KIND_CLEAR: begin
            for (i = 0; i < SLOTS; i++) shadow_mark[i] = lpht_pkg::MARK_NEVER;
            shadow_used = '0;
            o.status    = lpht_pkg::ST_DONE;
         end
         lpht_pkg::KIND_READ: begin
            o.slot = r.idx;
            o.mark = shadow_mark[r.idx];
            if (o.mark == lpht_pkg::MARK_FULL) begin
               o.status = lpht_pkg::ST_DONE;
               o.value  = shadow_val[r.idx];
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic add_vec(input lpht_pkg::kind_type k, input logic [31:0] key,
                          input logic [31:0] v, input logic [7:0] ix, input bit typed,
                          input lpht_pkg::status_type st, input logic [31:0] ov,
                          input logic [7:0] sl, input lpht_pkg::mark_type mk);
      vec_type e;
      e.rq       = '{kind: k, key: key, value: v, idx: ix};
      e.typed    = typed;
      e.rs       = '{status: st, value: ov, slot: sl, mark: mk};
      directed_q.push_back(e);
   endtask

   task automatic issue(input req_type r, input bit typed, input rsp_type given);
      rsp_type p;
      @(negedge clock);
      start          <= 1'b1;
      req_kind       <= r.kind;
      req_key        <= r.key;
      req_value_in   <= r.value;
      req_slot_index <= r.idx;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      p = table_response(r);
      pending_rsp.push_back(typed ? given : p);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic idle_gap();
      int n;
      n = $urandom_range(1, 15);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic write_limit(input logic [8:0] v);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      shadow_limit = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_ops(input int n, input bit quiet);
      req_type r;
      bit      idle_on;
      int      sel;
      int      j;
      idle_on = 1'b0;
      for (j = 0; j < n; j++) begin
         if (j % 30 == 0) idle_on = !quiet && ($urandom_range(0, 2) != 0);
         sel = $urandom_range(0, 99);
         if (sel < 38)      r.kind = lpht_pkg::KIND_SET;
         else if (sel < 63) r.kind = lpht_pkg::KIND_GET;
         else if (sel < 78) r.kind = lpht_pkg::KIND_DELETE;
         else if (sel < 92) r.kind = lpht_pkg::KIND_READ;
         else if (sel < 94) r.kind = lpht_pkg::KIND_CLEAR;
         else if (sel < 97) r.kind = lpht_pkg::kind_type'($urandom_range(5, 7));
         else               r.kind = lpht_pkg::KIND_READ;
         r.key   = ($urandom_range(0, 4) != 0) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : $urandom();
         r.value = $urandom();
         r.idx   = $urandom_range(0, 1) ? key_pool[$urandom_range(0, POOL_SIZE - 1)][7:0]
                                        : 8'($urandom_range(0, 255));
         if (idle_on && $urandom_range(0, 3) == 0) idle_gap();
         issue(r, 1'b0, '0);
      end
   endtask

   task automatic run_phase(input logic [8:0] lim, input int n, input bit quiet);
      logic [7:0] base;
      logic [7:0] off;
      int         j;
      write_limit(lim);
      base = $urandom_range(0, 255);
      for (j = 0; j < POOL_SIZE; j++) begin
         off         = $urandom_range(0, 23);
         key_pool[j] = $urandom();
         key_pool[j][7:0] = base + off;
      end
      random_ops(n, quiet);
   endtask

   // every slot occupied, then no-room set, full-length miss and tombstone reuse
   task automatic fill_phase();
      req_type    r;
      logic [7:0] d;
      int         i;
      write_limit(9'd256);
      r = '{kind: lpht_pkg::KIND_CLEAR, key: '0, value: '0, idx: '0};
      issue(r, 1'b0, '0);
      for (i = 0; i < SLOTS; i++) begin
         fill_keys[i]      = $urandom();
         fill_keys[i][7:0] = i[7:0];
         r = '{kind: lpht_pkg::KIND_SET, key: fill_keys[i], value: $urandom(), idx: '0};
         if ($urandom_range(0, 7) == 0) idle_gap();
         issue(r, 1'b0, '0);
      end
      r = '{kind: lpht_pkg::KIND_SET, key: $urandom(), value: $urandom(), idx: '0};
      issue(r, 1'b0, '0);
      r.kind = lpht_pkg::KIND_GET;
      issue(r, 1'b0, '0);
      for (i = 0; i < 8; i++) begin
         d = $urandom_range(0, 255);
         r = '{kind: lpht_pkg::KIND_DELETE, key: fill_keys[d], value: '0, idx: d};
         issue(r, 1'b0, '0);
         r = '{kind: lpht_pkg::KIND_SET, key: $urandom(), value: $urandom(), idx: '0};
         issue(r, 1'b0, '0);
      end
      for (i = 0; i < POOL_SIZE; i++) key_pool[i] = fill_keys[$urandom_range(0, SLOTS - 1)];
      random_ops(40, 1'b0);
   endtask

   always @(posedge clock) begin : response_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         got = '{status: rsp_status, value: rsp_value_out, slot: rsp_slot,
                 mark: rsp_prior_mark};
         if (pending_rsp.size() == 0) begin
            fault_cnt = fault_cnt + 1;
            if (fault_cnt <= 10)
               $display("unexpected response: status %0d value %h slot %0d mark %0d",
                        got.status, got.value, got.slot, got.mark);
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status || got.value !== want.value ||
                got.slot !== want.slot || got.mark !== want.mark) begin
               fault_cnt = fault_cnt + 1;
               if (fault_cnt <= 10)
                  $display({"response mismatch: status %0d/%0d value %h/%h ",
                            "slot %0d/%0d mark %0d/%0d (expected/actual)"},
                           want.status, got.status, want.value, got.value,
                           want.slot, got.slot, want.mark, got.mark);
            end
         end
      end
   end

   initial begin : stimulus
      int      i;
      vec_type e;
      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = '0;
      req_key        = '0;
      req_value_in   = '0;
      req_slot_index = '0;
      csr_valid      = 1'b0;
      csr_wdata      = '0;
      fault_cnt      = 0;
      for (i = 0; i < SLOTS; i++) begin
         shadow_key[i]  = '0;
         shadow_val[i]  = '0;
         shadow_mark[i] = lpht_pkg::MARK_NEVER;
      end
      shadow_used  = '0;
      shadow_limit = lpht_pkg::LIMIT_RESET;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_vec(lpht_pkg::KIND_GET, 32'h0, 32'h0, 8'd0, 1,
              lpht_pkg::ST_MISS, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_READ, 32'h0, 32'h0, 8'd0, 1,
              lpht_pkg::ST_MISS, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_READ, 32'hffffffff, 32'h0, 8'd255, 1,
              lpht_pkg::ST_MISS, 32'h0, 8'd255, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::kind_type'(5), 32'hffffffff, 32'hffffffff, 8'd255, 1,
              lpht_pkg::ST_MISS, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::kind_type'(6), 32'h0, 32'h0, 8'd0, 1,
              lpht_pkg::ST_MISS, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::kind_type'(7), 32'h12, 32'h34, 8'd56, 1,
              lpht_pkg::ST_MISS, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_DELETE, 32'h12345678, 32'h0, 8'd0, 1,
              lpht_pkg::ST_MISS, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_SET, 32'h0, 32'h0, 8'd0, 1,
              lpht_pkg::ST_DONE, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_SET, 32'hffffffff, 32'hffffffff, 8'd0, 1,
              lpht_pkg::ST_DONE, 32'h0, 8'd255, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_SET, 32'h100, 32'h5a5a5a5a, 8'd0, 0,
              lpht_pkg::ST_DONE, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_SET, 32'h1ff, 32'ha5a5a5a5, 8'd0, 0,
              lpht_pkg::ST_DONE, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_GET, 32'h1ff, 32'h0, 8'd0, 0,
              lpht_pkg::ST_DONE, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_GET, 32'hffffffff, 32'h0, 8'd0, 1,
              lpht_pkg::ST_DONE, 32'hffffffff, 8'd255, lpht_pkg::MARK_FULL);
      add_vec(lpht_pkg::KIND_DELETE, 32'h0, 32'h0, 8'd0, 0,
              lpht_pkg::ST_DONE, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_GET, 32'h100, 32'h0, 8'd0, 0,
              lpht_pkg::ST_DONE, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_READ, 32'h0, 32'h0, 8'd0, 0,
              lpht_pkg::ST_DONE, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_SET, 32'h300, 32'h1, 8'd0, 0,
              lpht_pkg::ST_DONE, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_SET, 32'h100, 32'h2, 8'd0, 0,
              lpht_pkg::ST_DONE, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_READ, 32'h0, 32'h0, 8'd1, 0,
              lpht_pkg::ST_DONE, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_DELETE, 32'h200, 32'h0, 8'd0, 0,
              lpht_pkg::ST_DONE, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_CLEAR, 32'hffffffff, 32'hffffffff, 8'd255, 1,
              lpht_pkg::ST_DONE, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_GET, 32'h100, 32'h0, 8'd0, 1,
              lpht_pkg::ST_MISS, 32'h0, 8'd0, lpht_pkg::MARK_NEVER);
      add_vec(lpht_pkg::KIND_READ, 32'h0, 32'h0, 8'd255, 1,
              lpht_pkg::ST_MISS, 32'h0, 8'd255, lpht_pkg::MARK_NEVER);

      for (i = 0; i < directed_q.size(); i++) begin
         e = directed_q[i];
         issue(e.rq, e.typed, e.rs);
      end

      run_phase(9'd1, 125, 1'b0);
      fill_phase();
      run_phase(9'd255, 125, 1'b0);
      run_phase(9'd2, 125, 1'b0);
      run_phase(9'($urandom_range(1, 256)), 125, 1'b0);
      run_phase(9'($urandom_range(1, 256)), 125, 1'b0);
      run_phase(lpht_pkg::LIMIT_RESET, 125, 1'b1);

      drain();
      repeat (300) @(posedge clock);
      if (fault_cnt == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/lpht_pkg.sv
rtl/linear_probe_hash_table.sv
bench/linear_probe_hash_table_tb.sv
